// ===== hw/rtl/iso2ep_pkg.sv =====
package iso2ep_pkg;

  // default field widths
  localparam int unsigned YEAR_BITS_DEF  = 16;
  localparam int unsigned FIELD_BITS_DEF = 8;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned EPOCH_W    = 42;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic signed [EPOCH_W-1:0] EPOCH_MAX = {1'b0, {(EPOCH_W-1){1'b1}}};
  localparam logic signed [EPOCH_W-1:0] EPOCH_MIN = {1'b1, {(EPOCH_W-1){1'b0}}};

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

  localparam int unsigned Q_DEPTH = 2;

  // floor(n / 12) = ((n >> 2) * RECIP3) >> RECIP3_SH for 16-bit n
  localparam int unsigned RECIP3_W  = 16;
  localparam int unsigned RECIP3    = 43691;
  localparam int unsigned RECIP3_SH = 17;

  // floor(n / 100) = ((n >> 2) * RECIP25) >> RECIP25_SH for n below 2^22
  localparam int unsigned RECIP25_W  = 20;
  localparam int unsigned RECIP25    = 671089;
  localparam int unsigned RECIP25_SH = 24;

  // days from year 0 (March based, offset by one 400-year era) to 1970-01-01, plus one
  localparam int unsigned DAYS_OFFSET = 865566;

  localparam int unsigned DOY_W = 9;

  // days from March 1 to the first day of month mp (0 = March)
  function automatic logic [DOY_W-1:0] month_start_doy(input logic [3:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/iso2ep_front.sv =====
module iso2ep_front #(
  parameter int unsigned YEAR_BITS  = iso2ep_pkg::YEAR_BITS_DEF,
  parameter int unsigned FIELD_BITS = iso2ep_pkg::FIELD_BITS_DEF,
  parameter int unsigned JOB_W      = 2 + YEAR_BITS + 5 * FIELD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [iso2ep_pkg::CHAR_W-1:0]   char_i,
  input  logic                            start_i,
  input  logic                            job_ready_i,
  output logic                            job_valid_o,
  output logic [JOB_W-1:0]                job_o
);

  localparam int unsigned AW = (YEAR_BITS > FIELD_BITS) ? YEAR_BITS : FIELD_BITS;
  localparam int unsigned NW = AW + 4;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_YEAR   = 3'd1;
  localparam logic [2:0] PH_MONTH  = 3'd2;
  localparam logic [2:0] PH_DAY    = 3'd3;
  localparam logic [2:0] PH_HOUR   = 3'd4;
  localparam logic [2:0] PH_MINUTE = 3'd5;
  localparam logic [2:0] PH_SECOND = 3'd6;

  localparam logic [NW-1:0] YEAR_LIM  = {{(NW-YEAR_BITS){1'b0}}, {YEAR_BITS{1'b1}}};
  localparam logic [NW-1:0] FIELD_LIM = {{(NW-FIELD_BITS){1'b0}}, {FIELD_BITS{1'b1}}};

  logic [2:0]            phase_q, phase_d;
  logic [AW-1:0]         acc_q, acc_d;
  logic                  clamp_q, clamp_d;
  logic [YEAR_BITS-1:0]  year_q, year_d;
  logic [FIELD_BITS-1:0] month_q, month_d, day_q, day_d;
  logic [FIELD_BITS-1:0] hour_q, hour_d, minute_q, minute_d;

  logic                  take;
  logic [2:0]            ph;
  logic [AW-1:0]         acc;
  logic                  clamp;
  logic                  is_digit;
  logic [NW-1:0]         acc_x, nxt, limit;
  logic [iso2ep_pkg::CHAR_W-1:0] want;
  logic                  emit, ok;

  assign take = in_valid_i & job_ready_i;

  always_comb begin
    ph       = start_i ? PH_YEAR : phase_q;
    acc      = start_i ? '0 : acc_q;
    clamp    = start_i ? 1'b0 : clamp_q;
    is_digit = (char_i >= iso2ep_pkg::CH_ZERO) && (char_i <= iso2ep_pkg::CH_NINE);
    acc_x    = NW'(acc);
    nxt      = (acc_x << 3) + (acc_x << 1) + NW'(char_i[3:0]);
    limit    = (ph == PH_YEAR) ? YEAR_LIM : FIELD_LIM;

    case (ph)
      PH_YEAR, PH_MONTH: want = iso2ep_pkg::CH_DASH;
      PH_DAY:            want = iso2ep_pkg::CH_T;
      default:           want = iso2ep_pkg::CH_COLON;
    endcase

    phase_d  = phase_q;
    acc_d    = acc_q;
    clamp_d  = clamp_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    emit     = 1'b0;
    ok       = 1'b0;

    if (take) begin
      if (start_i) begin
        phase_d  = PH_YEAR;
        acc_d    = '0;
        clamp_d  = 1'b0;
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
      end
      if ((ph >= PH_YEAR) && (ph <= PH_SECOND)) begin
        if (is_digit) begin
          if (nxt > limit) begin
            acc_d   = limit[AW-1:0];
            clamp_d = 1'b1;
          end else begin
            acc_d   = nxt[AW-1:0];
            clamp_d = clamp;
          end
        end else if (ph == PH_SECOND) begin
          emit    = 1'b1;
          ok      = (char_i == iso2ep_pkg::CH_DOT) || (char_i == iso2ep_pkg::CH_Z);
          phase_d = PH_IDLE;
        end else if (char_i != want) begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          case (ph)
            PH_YEAR:  year_d   = acc[YEAR_BITS-1:0];
            PH_MONTH: month_d  = acc[FIELD_BITS-1:0];
            PH_DAY:   day_d    = acc[FIELD_BITS-1:0];
            PH_HOUR:  hour_d   = acc[FIELD_BITS-1:0];
            default:  minute_d = acc[FIELD_BITS-1:0];
          endcase
          acc_d   = '0;
          phase_d = ph + 3'd1;
        end
      end
    end
  end

  assign job_valid_o = emit;
  assign job_o = {acc[FIELD_BITS-1:0], minute_q, hour_q, day_q, month_q, year_q, clamp, ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      clamp_q  <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      clamp_q  <= clamp_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
    end
  end

endmodule

// ===== hw/rtl/iso2ep_fifo.sv =====
module iso2ep_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = iso2ep_pkg::Q_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/iso2ep_back.sv =====
module iso2ep_back #(
  parameter int unsigned YEAR_BITS  = iso2ep_pkg::YEAR_BITS_DEF,
  parameter int unsigned FIELD_BITS = iso2ep_pkg::FIELD_BITS_DEF,
  parameter int unsigned JOB_W      = 2 + YEAR_BITS + 5 * FIELD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  logic [JOB_W-1:0]                   job_i,
  output logic                               job_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [iso2ep_pkg::EPOCH_W-1:0]     epoch_o,
  output logic                               res_ok_o,
  output logic                               res_sat_o
);

  localparam int unsigned EW     = iso2ep_pkg::EPOCH_W;
  localparam int unsigned FB     = FIELD_BITS;
  localparam int unsigned YP_W   = ((YEAR_BITS > FIELD_BITS) ? YEAR_BITS : FIELD_BITS) + 2;
  localparam int unsigned MQ_W   = FB - 3;
  localparam int unsigned P12_W  = (FB - 2) + iso2ep_pkg::RECIP3_W;
  localparam int unsigned H_W    = YP_W - 6;
  localparam int unsigned P25_W  = (YP_W - 2) + iso2ep_pkg::RECIP25_W;
  localparam int unsigned Y365_W = YP_W + 9;
  localparam int unsigned DAYS_W = YP_W + 10;
  localparam int unsigned PROD_W = DAYS_W + 17;
  localparam int unsigned HMS_W  = FB + 13;
  localparam int unsigned CMP_W  = (PROD_W + 1 > EW + 1) ? PROD_W + 1 : EW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MON  = 3'd1;
  localparam logic [2:0] ST_YEAR = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DAYS = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] st_q, st_d;

  logic                  ok_q, jsat_q;
  logic [YEAR_BITS-1:0]  year_q;
  logic [FB-1:0]         month_q, day_q, hour_q, min_q, sec_q;
  logic [MQ_W-1:0]       mq_q;
  logic [YP_W-1:0]       yp_q;
  logic [iso2ep_pkg::DOY_W-1:0] doy_q;
  logic [H_W-1:0]        h_q;
  logic [Y365_W-1:0]     y365_q;
  logic [DAYS_W-1:0]     days_q;
  logic [PROD_W-1:0]     prod_q;
  logic [HMS_W-1:0]      hms_q;

  logic                  out_valid_q;
  logic [EW-1:0]         out_epoch_q;
  logic                  out_ok_q, out_sat_q;

  logic [FB-1:0]         dm;
  logic [P12_W-1:0]      p12;
  logic [FB-1:0]         rem_full;
  logic [3:0]            mi, mp;
  logic                  mzero, dec;
  logic [YP_W-1:0]       yp_d;
  logic [P25_W-1:0]      p25;
  logic [DAYS_W-1:0]     days_d;
  logic [PROD_W-1:0]     days_x, prod_d;
  logic [HMS_W-1:0]      hms_d;
  logic [CMP_W-1:0]      total;
  logic                  over, under;
  logic [EW-1:0]         epoch_sel;
  logic                  load_out;

  assign job_pop_o = (st_q == ST_IDLE) & job_valid_i;
  assign load_out  = (st_q == ST_OUT) & (~out_valid_q | out_ready_i);

  always_comb begin
    // month carry: q = floor((month - 1) / 12)
    dm       = month_q - FB'(1);
    p12      = P12_W'(dm >> 2) * P12_W'(iso2ep_pkg::RECIP3);
    rem_full = dm - FB'({mq_q, 3'b000}) - FB'({mq_q, 2'b00});
    mzero    = (month_q == '0);
    mi       = mzero ? 4'd11 : rem_full[3:0];
    dec      = mzero | (mi < 4'd2);
    mp       = (mi < 4'd2) ? mi + 4'd10 : mi - 4'd2;
    yp_d     = YP_W'(year_q) + (mzero ? '0 : YP_W'(mq_q)) + YP_W'(400) - YP_W'(dec);

    p25      = P25_W'(yp_q >> 2) * P25_W'(iso2ep_pkg::RECIP25);

    days_d   = DAYS_W'(y365_q) + DAYS_W'(yp_q >> 2) - DAYS_W'(h_q) + DAYS_W'(h_q >> 2)
             + DAYS_W'(doy_q) + DAYS_W'(day_q) - DAYS_W'(iso2ep_pkg::DAYS_OFFSET);

    days_x   = PROD_W'($signed(days_q));
    prod_d   = days_x * PROD_W'(86400);
    hms_d    = HMS_W'(hour_q) * HMS_W'(3600) + HMS_W'(min_q) * HMS_W'(60) + HMS_W'(sec_q);

    total    = CMP_W'($signed(prod_q)) + CMP_W'(hms_q);
    over     = $signed(total) > $signed(CMP_W'(iso2ep_pkg::EPOCH_MAX));
    under    = $signed(total) < $signed(CMP_W'(iso2ep_pkg::EPOCH_MIN));
    if (over) begin
      epoch_sel = iso2ep_pkg::EPOCH_MAX;
    end else if (under) begin
      epoch_sel = iso2ep_pkg::EPOCH_MIN;
    end else begin
      epoch_sel = total[EW-1:0];
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (job_valid_i) st_d = ST_MON;
      ST_MON:  st_d = ST_YEAR;
      ST_YEAR: st_d = ST_DIV;
      ST_DIV:  st_d = ST_DAYS;
      ST_DAYS: st_d = ST_MUL;
      ST_MUL:  st_d = ST_OUT;
      ST_OUT:  if (load_out) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ok_q    <= job_i[0];
      jsat_q  <= job_i[1];
      year_q  <= job_i[2 +: YEAR_BITS];
      month_q <= job_i[2 + YEAR_BITS +: FB];
      day_q   <= job_i[2 + YEAR_BITS + FB +: FB];
      hour_q  <= job_i[2 + YEAR_BITS + 2 * FB +: FB];
      min_q   <= job_i[2 + YEAR_BITS + 3 * FB +: FB];
      sec_q   <= job_i[2 + YEAR_BITS + 4 * FB +: FB];
    end
    if (st_q == ST_MON) begin
      mq_q <= p12[iso2ep_pkg::RECIP3_SH +: MQ_W];
    end
    if (st_q == ST_YEAR) begin
      yp_q  <= yp_d;
      doy_q <= iso2ep_pkg::month_start_doy(mp);
    end
    if (st_q == ST_DIV) begin
      h_q    <= p25[iso2ep_pkg::RECIP25_SH +: H_W];
      y365_q <= Y365_W'(yp_q) * Y365_W'(365);
    end
    if (st_q == ST_DAYS) begin
      days_q <= days_d;
    end
    if (st_q == ST_MUL) begin
      prod_q <= prod_d;
      hms_q  <= hms_d;
    end
    if (load_out) begin
      out_ok_q    <= ok_q;
      out_epoch_q <= ok_q ? epoch_sel : '0;
      out_sat_q   <= jsat_q | (ok_q & (over | under));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign epoch_o     = out_epoch_q;
  assign res_ok_o    = out_ok_q;
  assign res_sat_o   = out_sat_q;

endmodule

// ===== hw/rtl/iso8601_timestamp_to_epoch_core.sv =====
// Timestamp text to Unix seconds.
// Input stream: one character per beat, s_axis_tuser_i marks the first character
// of a new timestamp (YYYY-MM-DDTHH:MM:SS then '.' or 'Z'). Output stream: one beat
// per finished or malformed timestamp; tuser[0] = well formed, tuser[1] = a field
// or the result was clamped, tdata = signed seconds (zero when malformed).
// Throughput: the parser takes one character every cycle while the job queue is
// not full. Each timestamp then runs through a conversion sequencer (month carry,
// year fold, divide by 100, day count, seconds multiply, sum and clamp) that takes
// a new job only once it is done with the last; a two-entry job queue sits
// between parser and sequencer. A result is delayed when earlier jobs are still
// queued or an earlier result is still stalled at the output.
// Stall: a stalled result holds in the output register; the sequencer waits,
// the queue fills, and tready drops only when both queue entries are taken.
// Reset: the parser is idle (characters ignored until a start beat), the queue
// is empty and no result is pending.
module iso8601_timestamp_to_epoch_core #(
  parameter int unsigned YEAR_BITS  = iso2ep_pkg::YEAR_BITS_DEF,
  parameter int unsigned FIELD_BITS = iso2ep_pkg::FIELD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [iso2ep_pkg::CHAR_W-1:0]         s_axis_tdata_i,   // [7:0] char_in
  input  logic                                  s_axis_tuser_i,   // [0] start_req
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [iso2ep_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,   // [41:0] epoch_seconds
  output logic [iso2ep_pkg::OUT_USER_W-1:0]     m_axis_tuser_o    // [0] valid_res, [1] saturated
);

  localparam int unsigned JOB_W = 2 + YEAR_BITS + 5 * FIELD_BITS;
  localparam int unsigned EW    = iso2ep_pkg::EPOCH_W;

  logic             fe_valid, q_full, q_empty, q_pop;
  logic [JOB_W-1:0] fe_job, q_job;
  logic [EW-1:0]    epoch;
  logic             res_ok, res_sat;

  assign s_axis_tready_o = ~q_full;

  iso2ep_front #(
    .YEAR_BITS (YEAR_BITS),
    .FIELD_BITS(FIELD_BITS),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .char_i     (s_axis_tdata_i),
    .start_i    (s_axis_tuser_i),
    .job_ready_i(~q_full),
    .job_valid_o(fe_valid),
    .job_o      (fe_job)
  );

  iso2ep_fifo #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fe_valid),
    .push_data_i(fe_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_data_o (q_job),
    .empty_o    (q_empty)
  );

  iso2ep_back #(
    .YEAR_BITS (YEAR_BITS),
    .FIELD_BITS(FIELD_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(~q_empty),
    .job_i      (q_job),
    .job_pop_o  (q_pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .epoch_o    (epoch),
    .res_ok_o   (res_ok),
    .res_sat_o  (res_sat)
  );

  assign m_axis_tdata_o = {{(iso2ep_pkg::OUT_DATA_W - EW){1'b0}}, epoch};
  assign m_axis_tuser_o = {res_sat, res_ok};

endmodule

// ===== hw/rtl/iso2ep_checker.sv =====
module iso2ep_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [iso2ep_pkg::CHAR_W-1:0]     s_axis_tdata_i,
  input logic                              s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [iso2ep_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [iso2ep_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned EW = iso2ep_pkg::EPOCH_W;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[EW-1:0] == '0)
    else $error("malformed timestamp carries nonzero seconds");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[iso2ep_pkg::OUT_DATA_W-1:EW] == '0)
    else $error("padding bits of result are not zero");

  // the edge seen in reset clears the output, so the next one shows no beat
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result beat offered during reset");

endmodule

bind iso8601_timestamp_to_epoch_core iso2ep_checker u_iso2ep_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

typedef enum int {
  PH_IDLE,
  PH_YEAR,
  PH_MONTH,
  PH_DAY,
  PH_HOUR,
  PH_MINUTE,
  PH_SECOND
} parse_phase_e;

class epoch_scoreboard;

  typedef struct {
    bit                                    well_formed;
    logic signed [iso2ep_pkg::EPOCH_W-1:0] seconds;
    bit                                    clamped;
  } epoch_result_t;

  localparam longint YEAR_MAX  = (64'd1 << iso2ep_pkg::YEAR_BITS_DEF) - 1;
  localparam longint FIELD_MAX = (64'd1 << iso2ep_pkg::FIELD_BITS_DEF) - 1;
  localparam longint SECS_MAX  = 64'sd2199023255551;
  localparam longint SECS_MIN  = -64'sd2199023255552;

  epoch_result_t pending_epochs[$];
  int            mismatches;

  parse_phase_e  phase;
  longint        digit_run;
  longint        year_v, month_v, day_v, hour_v, minute_v;
  bit            field_clamped;

  function new();
    phase = PH_IDLE;
    clear_fields();
  endfunction

  function void clear_fields();
    digit_run     = 0;
    year_v        = 0;
    month_v       = 0;
    day_v         = 0;
    hour_v        = 0;
    minute_v      = 0;
    field_clamped = 1'b0;
  endfunction

  // civil date and time to seconds since 1970, clamped to the result range; months out of range carry into the year
  function longint to_epoch(longint sec, inout bit sat);
    longint y, mi, mp, yp, era, yoe, doy, doe, days, total;
    y  = year_v;
    mi = month_v - 1;
    if (mi < 0) begin
      y  = y - 1;
      mi = 11;
    end else begin
      y  = y + mi / 12;
      mi = mi % 12;
    end
    if (mi < 2) begin
      y  = y - 1;
      mp = mi + 10;
    end else begin
      mp = mi - 2;
    end
    // shift by one era so the divisions see non-negative years
    yp    = y + 400;
    era   = yp / 400;
    yoe   = yp - era * 400;
    doy   = (153 * mp + 2) / 5;
    doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days  = era * 146097 + doe - 719468 - 146097 + day_v - 1;
    total = days * 86400 + hour_v * 3600 + minute_v * 60 + sec;
    if (total > SECS_MAX) begin
      total = SECS_MAX;
      sat   = 1'b1;
    end else if (total < SECS_MIN) begin
      total = SECS_MIN;
      sat   = 1'b1;
    end
    return total;
  endfunction

  // returns 1 when the parser acted on the character, 0 when it is idle and ignores it
  function bit take_char(logic [7:0] ch, bit first);
    epoch_result_t r;
    longint        limit, nxt, secs;
    logic [7:0]    sep;
    if (first) begin
      clear_fields();
      phase = PH_YEAR;
    end
    if (phase == PH_IDLE) return 1'b0;

    if (ch >= iso2ep_pkg::CH_ZERO && ch <= iso2ep_pkg::CH_NINE) begin
      limit = (phase == PH_YEAR) ? YEAR_MAX : FIELD_MAX;
      nxt   = digit_run * 10 + longint'(ch - iso2ep_pkg::CH_ZERO);
      if (nxt > limit) begin
        nxt           = limit;
        field_clamped = 1'b1;
      end
      digit_run = nxt;
      return 1'b1;
    end

    r.well_formed = 1'b0;
    r.seconds     = '0;
    r.clamped     = field_clamped;

    if (phase == PH_SECOND) begin
      if (ch == iso2ep_pkg::CH_DOT || ch == iso2ep_pkg::CH_Z) begin
        r.well_formed = 1'b1;
        secs          = to_epoch(digit_run, r.clamped);
        r.seconds     = secs[iso2ep_pkg::EPOCH_W-1:0];
      end
      pending_epochs.push_back(r);
      phase = PH_IDLE;
      return 1'b1;
    end

    case (phase)
      PH_YEAR, PH_MONTH: sep = iso2ep_pkg::CH_DASH;
      PH_DAY:            sep = iso2ep_pkg::CH_T;
      default:           sep = iso2ep_pkg::CH_COLON;
    endcase
    if (ch != sep) begin
      pending_epochs.push_back(r);
      phase = PH_IDLE;
      return 1'b1;
    end

    case (phase)
      PH_YEAR: begin
        year_v = digit_run;
        phase  = PH_MONTH;
      end
      PH_MONTH: begin
        month_v = digit_run;
        phase   = PH_DAY;
      end
      PH_DAY: begin
        day_v = digit_run;
        phase = PH_HOUR;
      end
      PH_HOUR: begin
        hour_v = digit_run;
        phase  = PH_MINUTE;
      end
      default: begin
        minute_v = digit_run;
        phase    = PH_SECOND;
      end
    endcase
    digit_run = 0;
    return 1'b1;
  endfunction

  function void check_beat(logic [iso2ep_pkg::OUT_DATA_W-1:0] data,
                           logic [iso2ep_pkg::OUT_USER_W-1:0] user);
    epoch_result_t                         want;
    logic signed [iso2ep_pkg::EPOCH_W-1:0] got;
    got = data[iso2ep_pkg::EPOCH_W-1:0];
    if (pending_epochs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: ok=%0b secs=%0d sat=%0b",
                 user[0], got, user[1]);
      return;
    end
    want = pending_epochs.pop_front();
    if (user[0] !== want.well_formed || got !== want.seconds || user[1] !== want.clamped) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected ok=%0b secs=%0d sat=%0b, got ok=%0b secs=%0d sat=%0b",
                 want.well_formed, want.seconds, want.clamped, user[0], got, user[1]);
    end
  endfunction

  function int outstanding();
    return pending_epochs.size();
  endfunction

endclass

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BEAT_TARGET = 700;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready_o;
  logic [iso2ep_pkg::CHAR_W-1:0]     s_axis_tdata = '0;
  logic                              s_axis_tuser = 1'b0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready = 1'b0;
  logic [iso2ep_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [iso2ep_pkg::OUT_USER_W-1:0] m_axis_tuser_o;

  epoch_scoreboard sb = new();

  int cycles;
  int sent_beats;
  int rx_hold_cycles;
  bit rx_holding;
  int tx_run_left, rx_run_left;
  bit tx_run_busy, rx_run_busy;

  iso8601_timestamp_to_epoch_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // alternate runs of random gaps with runs of back-to-back beats
  function automatic int draw_gap(ref int run_left, ref bit run_busy);
    if (run_left == 0) begin
      run_left = $urandom_range(5, 40);
      run_busy = ($urandom_range(0, 2) != 0);
    end
    run_left--;
    return run_busy ? $urandom_range(0, 14) : 0;
  endfunction

  task automatic send_beat(input logic [7:0] ch, input bit first);
    int gap;
    gap = rx_holding ? 0 : draw_gap(tx_run_left, tx_run_busy);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    void'(sb.take_char(ch, first));
    sent_beats++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == 0);
  endtask

  // drop the input while waiting so no beat is offered twice
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic void push_digits(ref logic [7:0] q[$], input int n);
    for (int i = 0; i < n; i++) q.push_back(iso2ep_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  task automatic send_random_stamp();
    logic [7:0] text[$];
    int         kind;
    int         cut;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      // raw noise, with a start here and there
      repeat ($urandom_range(1, 12))
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    push_digits(text, ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(0, 6));
    text.push_back(iso2ep_pkg::CH_DASH);
    push_digits(text, ($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 4));
    text.push_back(iso2ep_pkg::CH_DASH);
    push_digits(text, ($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 4));
    text.push_back(iso2ep_pkg::CH_T);
    push_digits(text, ($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 4));
    text.push_back(iso2ep_pkg::CH_COLON);
    push_digits(text, ($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 4));
    text.push_back(iso2ep_pkg::CH_COLON);
    push_digits(text, ($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 4));
    text.push_back($urandom_range(0, 1) ? iso2ep_pkg::CH_DOT : iso2ep_pkg::CH_Z);
    if (kind == 7) begin
      text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind == 8) begin
      // drop the tail; the next start abandons this one
      cut = $urandom_range(1, text.size() - 1);
      while (text.size() > cut) void'(text.pop_back());
    end
    foreach (text[i]) send_beat(text[i], i == 0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // result side
  initial begin
    int gap;
    int hold;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
        rx_holding     = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        rx_holding     = 1'b0;
      end else begin
        gap = draw_gap(rx_run_left, rx_run_busy);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_beat(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin
    int  stamps;
    bit  paused;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: epoch origin, empty fields, clamped and out-of-range fields,
    // bad separator, bad terminator, ignored text while idle, restart mid-parse
    send_text("1970-01-01T00:00:00Z");
    send_text("--T::.");
    send_text("99999-0-300T999:0:0.");
    send_text("2024/");
    send_beat("9", 1'b0);
    send_text("70-1");
    send_text("-13-0T24:60:99Z");
    send_text("1-1-1T1:1:1X");
    wait_drained();

    stamps = 0;
    paused = 1'b0;
    while (sent_beats < BEAT_TARGET) begin
      if (stamps == 8) rx_hold_cycles = 600;
      if (!paused && sent_beats > BEAT_TARGET / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      send_random_stamp();
      stamps++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
